// File: src/md5_pkg.sv
`default_nettype none
package md5_pkg;
    localparam int unsigned NumSteps = 64;

    typedef enum logic [0:0] {
        FUNC_DATA = 1'b0,
        FUNC_END  = 1'b1
    } t_func;

    typedef struct packed {
        logic [0:0] func;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_EMIT
    } t_state;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hEFCDAB89;
    localparam logic [31:0] InitC = 32'h98BADCFE;
    localparam logic [31:0] InitD = 32'h10325476;
    localparam logic [7:0]  PadByte = 8'h80;
    localparam logic [5:0]  LenStart = 6'd56;

    function automatic logic [31:0] step_const(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] sel);
        logic [4:0] r;
        unique case (sel)
            4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
            4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
            4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] k;
        unique case (i[5:4])
            2'd0: k = i[3:0];
            2'd1: k = 4'(5 * i[3:0] + 1);
            2'd2: k = 4'(3 * i[3:0] + 5);
            default: k = 4'(7 * i[3:0]);
        endcase
        return k;
    endfunction
endpackage
`default_nettype wire

// File: src/md5_if.sv
`default_nettype none
interface md5_req_if;
    import md5_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface md5_rsp_if;
    import md5_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/md5_hash_engine_core.sv
// MD5 engine. Request channel carries func and data_byte; func 0 absorbs one
// byte, func 1 pads the message and produces the digest. The response channel
// returns four words A..D (word_index 0..3, last_word on D), bytes of each
// word least significant first.
// A two-entry request queue decouples the input from the back end, which packs
// bytes, runs compression and pads.
// Throughput: one byte per cycle while packing; every 64th byte starts a
// compression (one MD5 step per cycle, single round unit) during which the
// back end takes no bytes. An end request pads and writes the length over
// one or two compressions, then emits four response words. The response
// sits in an output register; while the receiver stalls, the back end
// holds and the queue fills, then ready drops.
// Reset (synchronous, active low) restores the initial chaining values and
// clears the byte and bit counts and the queue.
`default_nettype none
module md5_hash_engine_core
    import md5_pkg::*;
(
    input  wire i_clk,
    input  wire i_rst_n,
    md5_req_if.sink   req,
    md5_rsp_if.source rsp
);
    md5_req_if q ();

    md5_fifo u_fifo (.i_clk, .i_rst_n, .s(req), .m(q.source));
    md5_back u_back (.i_clk, .i_rst_n, .s(q.sink), .m(rsp));
endmodule
`default_nettype wire

// File: src/md5_fifo.sv
`default_nettype none
module md5_fifo
    import md5_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    md5_req_if.sink   s,
    md5_req_if.source m
);
    // two-entry request queue between front and back
    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign s.ready   = (r_cnt != 2'd2);
    assign m.valid   = (r_cnt != 2'd0);
    assign m.payload = r_mem[r_rp];
    assign w_push    = s.valid && s.ready;
    assign w_pop     = m.valid && m.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= s.payload;
    end
endmodule
`default_nettype wire

// File: src/md5_back.sv
`default_nettype none
module md5_back
    import md5_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    md5_req_if.sink   s,
    md5_rsp_if.source m
);
    t_state      r_state, n_state;
    logic [31:0] r_buf [16];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_step;
    logic        r_fin;      // compression belongs to end-of-message padding
    logic        r_done;     // length bytes written, next compression is the final one
    logic [1:0]  r_widx;
    logic        r_ov;
    t_rsp        r_out;

    logic        w_put;
    logic [7:0]  w_byte;
    logic [31:0] w_f, w_t, w_rot, w_nb;
    logic [4:0]  w_r;

    always_comb begin
        unique case (r_step[5:4])
            2'd0: w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1: w_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
        w_t   = r_a + w_f + r_buf[msg_index(r_step)] + step_const(r_step);
        w_r   = rot_amount({r_step[5:4], r_step[1:0]});
        w_rot = (w_t << w_r) | (w_t >> (6'd32 - {1'b0, w_r}));
        w_nb  = r_b + w_rot;
    end

    // output register frees when empty or taken
    logic w_ofree;
    assign w_ofree = !r_ov || m.ready;
    assign m.valid = r_ov;
    assign m.payload = r_out;
    assign s.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        w_put   = 1'b0;
        w_byte  = s.payload.data_byte;
        unique case (r_state)
            ST_IDLE: begin
                if (s.valid) begin
                    w_put = 1'b1;
                    if (s.payload.func == FUNC_END) begin
                        w_byte  = PadByte;
                        n_state = (r_fill == 6'd63) ? ST_COMP
                                : (6'(r_fill + 1) == LenStart) ? ST_LEN : ST_PAD;
                    end else if (r_fill == 6'd63) begin
                        n_state = ST_COMP;
                    end
                end
            end
            ST_PAD: begin
                w_put  = 1'b1;
                w_byte = 8'h00;
                if (r_fill == 6'd63) n_state = ST_COMP;
                else if (6'(r_fill + 1) == LenStart) n_state = ST_LEN;
            end
            ST_LEN: begin
                w_put  = 1'b1;
                w_byte = r_len[8 * r_fill[2:0] +: 8];
                if (r_fill == 6'd63) n_state = ST_COMP;
            end
            ST_COMP: begin
                // after a padding compression: go on padding or emit once length is in
                if (r_step == 6'(NumSteps - 1)) begin
                    if (!r_fin) n_state = ST_IDLE;
                    else if (r_done) n_state = ST_EMIT;
                    else n_state = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (w_ofree && r_widx == 2'd3) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_put) r_buf[r_fill[5:2]][8 * r_fill[1:0] +: 8] <= w_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_step  <= '0;
            r_fin   <= 1'b0;
            r_done  <= 1'b0;
            r_widx  <= '0;
            r_ov    <= 1'b0;
            r_h[0]  <= InitA; r_h[1] <= InitB; r_h[2] <= InitC; r_h[3] <= InitD;
        end else begin
            r_state <= n_state;
            if (w_put) r_fill <= 6'(r_fill + 1);
            if (r_state == ST_IDLE && s.valid) begin
                if (s.payload.func == FUNC_END) begin
                    r_len <= r_bits;
                    r_fin <= 1'b1;
                    r_done <= 1'b0;
                end else begin
                    r_bits <= 64'(r_bits + 64'd8);
                end
            end
            if (r_state == ST_LEN && r_fill == 6'd63) r_done <= 1'b1;
            if (n_state == ST_COMP && r_state != ST_COMP) begin
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                r_step <= '0;
            end else if (r_state == ST_COMP) begin
                r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= w_nb;
                r_step <= 6'(r_step + 1);
                if (r_step == 6'(NumSteps - 1)) begin
                    r_h[0] <= r_h[0] + r_d;
                    r_h[1] <= r_h[1] + w_nb;
                    r_h[2] <= r_h[2] + r_b;
                    r_h[3] <= r_h[3] + r_c;
                end
            end
            if (r_state == ST_EMIT && w_ofree) begin
                r_ov  <= 1'b1;
                r_out <= '{digest_word: r_h[r_widx], word_index: r_widx,
                           last_word: (r_widx == 2'd3)};
                r_widx <= 2'(r_widx + 1);
                if (r_widx == 2'd3) begin
                    r_h[0] <= InitA; r_h[1] <= InitB; r_h[2] <= InitC; r_h[3] <= InitD;
                    r_fill <= '0;
                    r_bits <= '0;
                    r_fin  <= 1'b0;
                end
            end else if (m.ready) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// File: src/md5_checker.sv
`default_nettype none
module md5_checker
    import md5_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [1:0]  rsp_idx,
    input wire        rsp_last
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> (rsp_last == (rsp_idx == 2'd3))) else $error("last_word mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_idx)) else $error("stall drop");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_ready && !rsp_last |=> !rsp_valid || rsp_idx == $past(rsp_idx) + 2'd1)
        else $error("word order");
endmodule

bind md5_hash_engine_core md5_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_idx(rsp.payload.word_index), .rsp_last(rsp.payload.last_word));
`default_nettype wire
